@@ hdl/swst_pkg.sv @@
package swst_pkg;

	// Window depth and sample width.
	localparam int WINDOW      = 10;
	localparam int SAMPLE_BITS = 16;

	// Fixed result field widths.
	localparam int COUNT_BITS = 4;
	localparam int MEAN_W     = 24;
	localparam int FRAC_BITS  = 8;

	// Derived widths.
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = SAMPLE_BITS + CNT_W;
	localparam int DVD_W  = SUM_W + FRAC_BITS;
	localparam int DIV_CW = $clog2(DVD_W);
	localparam int CMP_W  = ((DVD_W > MEAN_W) ? DVD_W : MEAN_W) + 1;

	// Saturation limits of the mean, as magnitudes.
	localparam logic [CMP_W-1:0] MEAN_POS_LIM = CMP_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
	localparam logic [CMP_W-1:0] MEAN_NEG_LIM = CMP_W'(64'd1 << (MEAN_W - 1));

	typedef enum logic {
		OP_STORE = 1'b0,
		OP_STATS = 1'b1
	} opcode_t;

endpackage

@@ hdl/swst_if.sv @@
interface swst_in_if import swst_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [SAMPLE_BITS-1:0] sample_value;

	modport source (output valid, output opcode, output sample_value, input ready);
	modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface swst_out_if import swst_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic                          empty_res;
	logic [COUNT_BITS-1:0]         sample_count;
	logic signed [SAMPLE_BITS-1:0] min_value;
	logic signed [SAMPLE_BITS-1:0] max_value;
	logic signed [MEAN_W-1:0]      mean_q8;

	modport source (output valid, output empty_res, output sample_count, output min_value,
		output max_value, output mean_q8, input ready);
	modport sink   (input valid, input empty_res, input sample_count, input min_value,
		input max_value, input mean_q8, output ready);
endinterface

@@ hdl/swst_ring.sv @@
module swst_ring import swst_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic signed [SAMPLE_BITS-1:0] wr_data,
	input  logic [PTR_W-1:0]              rd_addr,
	output logic signed [SAMPLE_BITS-1:0] rd_data,
	output logic [CNT_W-1:0]              count
);

	logic signed [SAMPLE_BITS-1:0] mem [WINDOW];
	logic [PTR_W-1:0]              wr_ptr_q;
	logic [CNT_W-1:0]              count_q;
	logic signed [SAMPLE_BITS-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else if (wr_en) begin
			if (wr_ptr_q == PTR_W'(WINDOW - 1)) begin
				wr_ptr_q <= '0;
			end else begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (count_q != CNT_W'(WINDOW)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Plain store with one write port and a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign count   = count_q;

endmodule

@@ hdl/swst_div.sv @@
module swst_div import swst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic              busy_q;
	logic [DIV_CW-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dq_q;
	logic [CNT_W:0]    trial;
	logic              qbit;
	logic [CNT_W:0]    diff;

	// One restoring step per cycle: shift in the next dividend bit, subtract when it fits.
	always_comb begin
		trial = {rem_q, dq_q[DVD_W-1]};
		qbit  = (trial >= {1'b0, divisor});
		diff  = trial - {1'b0, divisor};
	end

	assign done = busy_q && (step_q == DIV_CW'(DVD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], qbit};
		end
	end

	assign quotient = dq_q;

endmodule

@@ hdl/sliding_window_stats_top.sv @@
// Sample transaction: stored in the ring, no result; the input stays ready for the next transaction.
// Stats transaction: the result (n = stored samples) comes from a scan of the n samples in the
// sample ring, then a bit-serial divider, then the output register.
// An empty window skips the scan and the division and goes straight to the output register.
// The input is not ready during a stats transaction, only again once its result is registered.
// Reset (arst_n low, asynchronous) empties the window and drops any pending result.
module sliding_window_stats_top import swst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	swst_in_if.sink     req,
	swst_out_if.source  rsp
);

	// The sequencer walks through the scan and the division (skipped for an
	// empty window), then parks the result in the output register. A finished
	// result may wait there while the block already takes further transactions.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic                          req_acc;
	logic                          stats_acc;
	logic                          wr_en;
	logic                          scan_issue;
	logic                          div_start;
	logic                          div_done;
	logic                          rsp_free;

	logic [CNT_W-1:0]              ring_count;
	logic signed [SAMPLE_BITS-1:0] rd_data;
	logic [CNT_W-1:0]              n_q;
	logic [CNT_W-1:0]              idx_q;
	logic                          rd_vld_s1;
	logic                          empty_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] lo_q;
	logic signed [SAMPLE_BITS-1:0] hi_q;

	logic [SUM_W-1:0]              abs_sum;
	logic [DVD_W-1:0]              dividend;
	logic [DVD_W-1:0]              quotient;
	logic [CMP_W-1:0]              quot_x;
	logic [CMP_W-1:0]              quot_neg;
	logic signed [MEAN_W-1:0]      mean_c;

	logic                          out_valid_q;
	logic                          out_empty_q;
	logic [COUNT_BITS-1:0]         out_count_q;
	logic signed [SAMPLE_BITS-1:0] out_min_q;
	logic signed [SAMPLE_BITS-1:0] out_max_q;
	logic signed [MEAN_W-1:0]      out_mean_q;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign wr_en     = req_acc && (req.opcode == OP_STORE);
	assign stats_acc = req_acc && (req.opcode == OP_STATS);

	// The ring read is registered, so a scan issues addresses 0 to n-1 and
	// accumulates each sample in the following cycle. The division starts once the
	// last sample has reached the running sum.
	assign scan_issue = (state_q == ST_SCAN) && (idx_q != n_q);
	assign div_start  = (state_q == ST_SCAN) && (idx_q == n_q) && !rd_vld_s1;
	assign rsp_free   = !out_valid_q || rsp.ready;

	swst_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (req.sample_value),
		.rd_addr (idx_q[PTR_W-1:0]),
		.rd_data (rd_data),
		.count   (ring_count)
	);

	// The divider works on magnitudes; the sign of the sum is restored afterwards,
	// which gives truncation toward zero.
	assign abs_sum  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign dividend = DVD_W'(abs_sum) << FRAC_BITS;

	swst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Sign and saturation of the quotient. The sum is unchanged while the
	// divider runs and while the result waits for the output register.
	always_comb begin
		quot_x   = CMP_W'(quotient);
		quot_neg = -quot_x;
		if (sum_q[SUM_W-1]) begin
			if (quot_x > MEAN_NEG_LIM) begin
				mean_c = MEAN_W'(MEAN_NEG_LIM);
			end else begin
				mean_c = quot_neg[MEAN_W-1:0];
			end
		end else begin
			if (quot_x > MEAN_POS_LIM) begin
				mean_c = MEAN_W'(MEAN_POS_LIM);
			end else begin
				mean_c = quot_x[MEAN_W-1:0];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stats_acc) begin
					state_d = (ring_count == '0) ? ST_OUT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (div_start) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (stats_acc) begin
				idx_q <= '0;
			end else if (scan_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if ((state_q == ST_OUT) && rsp_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Running statistics. Minimum and maximum start from the far ends of the
	// sample range so that the first sample replaces both.
	always_ff @(posedge clk) begin
		if (stats_acc) begin
			n_q     <= ring_count;
			empty_q <= (ring_count == '0);
			sum_q   <= '0;
			lo_q    <= {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
			hi_q    <= {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
		end else if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data);
			if (rd_data < lo_q) begin
				lo_q <= rd_data;
			end
			if (rd_data > hi_q) begin
				hi_q <= rd_data;
			end
		end
	end

	// Output register; an empty window reports zero in every field but the flag.
	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && rsp_free) begin
			out_empty_q <= empty_q;
			out_count_q <= COUNT_BITS'(n_q);
			out_min_q   <= empty_q ? '0 : lo_q;
			out_max_q   <= empty_q ? '0 : hi_q;
			out_mean_q  <= empty_q ? '0 : mean_c;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.empty_res    = out_empty_q;
	assign rsp.sample_count = out_count_q;
	assign rsp.min_value    = out_min_q;
	assign rsp.max_value    = out_max_q;
	assign rsp.mean_q8      = out_mean_q;

`ifndef ASSERT_OFF
	// The fill level never passes the window depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ring_count <= CNT_W'(WINDOW))
		else $error("sample count beyond window depth");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the division step");

	// A stats request on an empty window skips scan and division.
	a_empty_shortcut: assert property (@(posedge clk) disable iff (!arst_n)
		(stats_acc && (ring_count == '0)) |=> (state_q == ST_OUT))
		else $error("empty window did not go straight to the result");

	// An empty result carries zeros in its count and mean.
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.empty_res) |-> ((rsp.sample_count == '0) && (rsp.mean_q8 == '0)))
		else $error("empty result with non-zero fields");
`endif

endmodule
